FILE: rtl/bldc_hall_commutation_controller_top_macros.svh
// ----------------------------------------------------------------------------
// bldc_hall_commutation_controller_top_macros
// Assertion macros for the Hall commutation controller.
// ----------------------------------------------------------------------------
// Each macro is a labelled concurrent assertion clocked on clk; BHC_ASSERT is
// quiet in reset, BHC_ASSERT_RST also checks through reset.
`ifndef BLDC_HALL_COMMUTATION_CONTROLLER_TOP_MACROS_SVH
`define BLDC_HALL_COMMUTATION_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BHC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BHC_ASSERT(label, prop, msg)
`define BHC_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: rtl/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared constants and the per-channel state record of the Hall controller.
// ----------------------------------------------------------------------------
package bhc_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int DIR_STEPS_DEF = 6;
  localparam int STALL_DEF     = 10000;
  localparam int RUN_CAP       = 10000;
  localparam int MAP_REGS      = 4;

  // configuration register indexes
  localparam logic [2:0] REG_MAP0      = 3'd0;
  localparam logic [2:0] REG_MAP1      = 3'd1;
  localparam logic [2:0] REG_MAP2      = 3'd2;
  localparam logic [2:0] REG_MAP3      = 3'd3;
  localparam logic [2:0] REG_MAX_STEP  = 3'd4;
  localparam logic [2:0] REG_RAMP_INT  = 3'd5;
  localparam logic [2:0] REG_CUR_LIMIT = 3'd6;
  localparam logic [2:0] REG_CUR_GAIN  = 3'd7;

  typedef struct packed {
    logic [2:0]         last_hall;
    logic [7:0]         ramp_count;
    logic signed [16:0] prev_signed_duty;
    logic [15:0]        applied_duty;
    logic               applied_dir;
    logic [2:0]         prev_step;
    logic               prev_move_dir;
    logic [13:0]        same_dir_run;
    logic [15:0]        tick_count;
    logic signed [16:0] speed_ticks;
    logic [31:0]        encoder;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

endpackage

FILE: rtl/bldc_hall_commutation_controller_top.sv
// ----------------------------------------------------------------------------
// bldc_hall_commutation_controller_top
// Six-step Hall commutation controller, four channels, state held in RAM.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | beat carries
// in      | sink      | in_valid/stall  | channel, hall, current, command
// out     | source    | out_valid/stall | drive settings, encoder, speed
// cfg     | sink      | cfg_valid/ready | register index, data
//
// One beat per cycle sustained while the output does not stall; the result
// is offered from the output register (stage 1 RAM read, stage 2 update
// into the output register). Stage 1 issues the product and the map lookup;
// the state read for an item is issued as it moves into stage 2, and
// stage 2 writes back. A beat for the same channel directly behind takes the
// written state forwarded. Reset loads each channel's state by a sweep over
// the channels, input stalled meanwhile. Output stall holds the whole pipe.
// ----------------------------------------------------------------------------
`include "bldc_hall_commutation_controller_top_macros.svh"

module bldc_hall_commutation_controller_top
  import bhc_pkg::*;
#(
  parameter int CHANNELS         = CHANNELS_DEF,
  parameter int DIR_CHANGE_STEPS = DIR_STEPS_DEF,
  parameter int STALL_TICKS      = STALL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         channel,
  input  logic [2:0]         raw_hall,
  input  logic signed [15:0] current,
  input  logic               enable,
  input  logic [15:0]        duty_cmd,
  input  logic               dir_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_channel,
  output logic               drive_active,
  output logic [2:0]         comm_step,
  output logic               drive_dir,
  output logic [15:0]        drive_duty,
  output logic [31:0]        step_count,
  output logic signed [16:0] ticks_per_step,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RD = (CHANNELS > 1) ? CHANNELS : 2;

  // configuration
  logic [23:0]        hall_map [MAP_REGS];
  logic [15:0]        max_duty_step;
  logic [7:0]         ramp_interval;
  logic signed [15:0] current_limit;
  logic [15:0]        current_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_REGS; i++) hall_map[i] <= '0;
      max_duty_step <= 16'd50;
      ramp_interval <= 8'd10;
      current_limit <= 16'sd10000;
      current_gain  <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3: hall_map[cfg_index[1:0]] <= cfg_data;
        REG_MAX_STEP:  max_duty_step <= cfg_data[15:0];
        REG_RAMP_INT:  ramp_interval <= cfg_data[7:0];
        REG_CUR_LIMIT: current_limit <= cfg_data[15:0];
        REG_CUR_GAIN:  current_gain  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // reset sweep
  logic          init;
  logic [AW:0]   init_cnt;
  chan_state_t   init_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      init     <= 1'b1;
      init_cnt <= '0;
    end else if (init) begin
      if (32'(init_cnt) == CHANNELS - 1) init <= 1'b0;
      init_cnt <= init_cnt + 1'b1;
    end
  end

  always_comb begin
    init_st = '0;
    init_st.ramp_count = 8'({init_cnt, 1'b0});
  end

  // pipeline
  logic        adv;
  logic        v1, v2;
  logic [1:0]  ch1, ch2;
  logic        ok1, ok2;
  logic [2:0]  hall1;
  logic        en1, dir1;
  logic [15:0] duty1;
  logic        over1, over2;
  logic signed [16:0] ovr1;
  logic [2:0]  hall2;
  logic        en2, dir2;
  logic [15:0] duty2;
  logic [31:0] lower2;
  logic [23:0] map2;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = init || !adv;

  logic in_ok;
  assign in_ok = 32'(channel) < CHANNELS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && !init;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch1   <= channel;
      ok1   <= in_ok;
      hall1 <= raw_hall;
      en1   <= enable;
      duty1 <= duty_cmd;
      dir1  <= dir_cmd;
      over1 <= current > current_limit;
      ovr1  <= 17'(current) - 17'(current_limit);
      ch2   <= ch1;
      ok2   <= ok1;
      hall2 <= hall1;
      en2   <= en1;
      duty2 <= duty1;
      dir2  <= dir1;
      over2 <= over1;
      lower2 <= 32'((33'(ovr1[15:0]) + (ovr1[16] ? 33'h10000 : 33'd0))
                    * 33'(current_gain) >> 8);
      map2  <= hall_map[ch1];
    end
  end

  // state memory
  chan_state_t ram_rd, st_cur, st_next, fwd_st;
  logic        we;
  logic [AW-1:0] waddr;
  chan_state_t   wdata;
  logic          fwd_hit;
  logic [2:0]    step_n;
  logic [15:0]   duty_n;
  logic          dir_n;
  logic [AW-1:0] raddr;

  // read for the item entering stage 2; under stall re-read the one held there
  assign raddr = adv ? AW'(ch1) : AW'(ch2);

  bhc_ram #(.WIDTH(STATE_W), .DEPTH(RD)) u_state (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(ram_rd)
  );

  always_ff @(posedge clk) begin
    fwd_hit <= we && (waddr == raddr);
    fwd_st  <= wdata;
  end

  assign st_cur = fwd_hit ? fwd_st : ram_rd;

  bhc_update #(.DIR_CHANGE_STEPS(DIR_CHANGE_STEPS), .STALL_TICKS(STALL_TICKS)) u_upd (
    .st(st_cur), .raw_hall(hall2), .enable(en2), .duty_cmd(duty2), .dir_cmd(dir2),
    .over(over2), .lower(lower2), .hall_map(map2), .max_duty_step(max_duty_step),
    .ramp_interval(ramp_interval), .st_next(st_next), .comm_step(step_n),
    .drive_duty(duty_n), .drive_dir(dir_n)
  );

  // the update fires as stage 2 moves into the output register
  logic fire;
  assign fire  = v2 && adv && ok2;
  assign we    = init || fire;
  assign waddr = init ? AW'(init_cnt) : AW'(ch2);
  assign wdata = init ? init_st : st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_channel    <= ch2;
      drive_active   <= ok2 && en2;
      comm_step      <= ok2 ? step_n : 3'd0;
      drive_dir      <= ok2 && dir_n;
      drive_duty     <= ok2 ? duty_n : 16'd0;
      step_count     <= ok2 ? st_next.encoder : 32'd0;
      ticks_per_step <= ok2 ? st_next.speed_ticks : 17'sd0;
    end
  end

  `BHC_ASSERT(a_no_in_in_init, init |-> in_stall, "input taken during state sweep")
  `BHC_ASSERT(a_hold_out, (out_valid && out_stall) |=> out_valid && $stable(step_count), "result lost under stall")
  `BHC_ASSERT(a_dis_zero, (out_valid && !drive_active) |-> drive_duty == 16'd0, "duty while floating")
  `BHC_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "output valid after reset")

endmodule

FILE: rtl/bhc_ram.sv
// ----------------------------------------------------------------------------
// bhc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bhc_update.sv
// ----------------------------------------------------------------------------
// bhc_update
// Stage-2 datapath: from one channel's state and one tick, the next state
// and the result fields. The overshoot product comes in registered.
// ----------------------------------------------------------------------------
module bhc_update
  import bhc_pkg::*;
#(
  parameter int DIR_CHANGE_STEPS = DIR_STEPS_DEF,
  parameter int STALL_TICKS      = STALL_DEF
) (
  input  chan_state_t        st,
  input  logic [2:0]         raw_hall,
  input  logic               enable,
  input  logic [15:0]        duty_cmd,
  input  logic               dir_cmd,
  input  logic               over,
  input  logic [31:0]        lower,
  input  logic [23:0]        hall_map,
  input  logic [15:0]        max_duty_step,
  input  logic [7:0]         ramp_interval,
  output chan_state_t        st_next,
  output logic [2:0]         comm_step,
  output logic [15:0]        drive_duty,
  output logic               drive_dir
);

  logic [2:0]         hall_q;
  logic [2:0]         step;
  logic signed [17:0] target;
  logic signed [17:0] diff;
  logic [17:0]        mag;
  logic signed [17:0] moved;
  logic [15:0]        duty_r;
  logic               fwd;
  logic               back;
  logic               same;
  logic [13:0]        run;
  logic [15:0]        tick;

  always_comb begin
    st_next = st;
    hall_q  = (raw_hall >= 3'd1 && raw_hall <= 3'd6) ? raw_hall : st.last_hall;
    st_next.last_hall = hall_q;
    step   = hall_map[{1'b0, hall_q, 1'b0} + {2'b00, hall_q} +: 3];
    target = dir_cmd ? $signed({2'b00, duty_cmd}) : -$signed({2'b00, duty_cmd});
    diff   = target - 18'(st.prev_signed_duty);
    mag    = diff[17] ? 18'(-diff) : 18'(diff);
    moved  = diff[17] ? 18'(st.prev_signed_duty) - $signed({2'b00, max_duty_step})
                      : 18'(st.prev_signed_duty) + $signed({2'b00, max_duty_step});
    duty_r = st.applied_duty;
    if (enable) begin
      if (st.ramp_count < ramp_interval) begin
        st_next.ramp_count = st.ramp_count + 8'd1;
      end else begin
        st_next.ramp_count = '0;
        if (mag <= {2'b00, max_duty_step}) begin
          duty_r = duty_cmd;
          st_next.applied_dir = dir_cmd;
          st_next.prev_signed_duty = 17'(target);
        end else begin
          duty_r = moved[17] ? 16'(-moved) : moved[15:0];
          st_next.applied_dir = !moved[17];
          st_next.prev_signed_duty = 17'(moved);
        end
      end
      if (over) begin
        duty_r = (lower >= {16'd0, duty_r}) ? 16'd0 : 16'(32'(duty_r) - lower);
      end
      st_next.applied_duty = duty_r;
    end

    fwd  = (step > st.prev_step || (step == 3'd0 && st.prev_step == 3'd5))
           && !(step == 3'd5 && st.prev_step == 3'd0);
    back = !fwd && (step < st.prev_step || (step == 3'd5 && st.prev_step == 3'd0));
    tick = st.tick_count;
    same = 1'b0;
    run  = st.same_dir_run;
    if (fwd || back) begin
      same = fwd ? st.prev_move_dir : !st.prev_move_dir;
      st_next.encoder = fwd ? st.encoder + 32'd1 : st.encoder - 32'd1;
      run = same ? ((st.same_dir_run < 14'(RUN_CAP)) ? st.same_dir_run + 14'd1
                                                      : st.same_dir_run) : 14'd0;
      st_next.same_dir_run = run;
      if (32'(run) >= 32'(DIR_CHANGE_STEPS)) begin
        st_next.speed_ticks = fwd ? $signed({1'b0, tick}) : -$signed({1'b0, tick});
      end
      tick = '0;
      st_next.prev_move_dir = fwd;
    end
    if (32'(tick) > 32'(STALL_TICKS)) begin
      st_next.speed_ticks = '0;
    end else begin
      tick = tick + 16'd1;
    end
    if (tick != 16'hFFFF) begin
      tick = tick + 16'd1;
    end
    st_next.tick_count = tick;
    st_next.prev_step  = step;
    comm_step  = step;
    drive_duty = enable ? duty_r : 16'd0;
    drive_dir  = enable ? st_next.applied_dir : 1'b0;
  end

endmodule

FILE: dv/bldc_hall_commutation_controller_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bldc_hall_commutation_controller_top_tb
// Self-checking bench: directed and random control ticks against a per-channel
// behavioural predictor, with random idling on both channels and config phases.
// ----------------------------------------------------------------------------
module bldc_hall_commutation_controller_top_tb
  import bhc_pkg::*;
;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int STALL_LIMIT  = 10000;
  localparam int DIR_STEPS    = 6;

  typedef struct {
    logic [1:0]         chan;
    logic [2:0]         hall;
    logic signed [15:0] cur;
    logic               en;
    logic [15:0]        duty;
    logic               dir;
  } tick_t;

  typedef struct {
    logic [1:0]         chan;
    logic               active;
    logic [2:0]         step;
    logic               dir;
    logic [15:0]        duty;
    logic [31:0]        count;
    logic signed [16:0] speed;
  } drive_t;

  // Predicts drive settings per tick and holds the ones still awaited.
  class drive_scoreboard;
    logic [23:0]        hall_map [4];
    int                 max_step, ramp_int, cur_lim, gain;
    logic [2:0]         last_hall [4];
    int                 ramp_cnt [4];
    int                 prev_sduty [4];
    int                 app_duty [4];
    logic               app_dir [4];
    int                 prev_step [4];
    logic               prev_mdir [4];
    int                 dir_run [4];
    int                 ticks [4];
    int                 speed [4];
    logic [31:0]        encoder [4];
    drive_t             awaited [$];
    int                 errors;

    function new();
      max_step = 50; ramp_int = 10; cur_lim = 10000; gain = 256; errors = 0;
      for (int c = 0; c < 4; c++) begin
        hall_map[c] = '0; last_hall[c] = '0; ramp_cnt[c] = 2 * c;
        prev_sduty[c] = 0; app_duty[c] = 0; app_dir[c] = 0; prev_step[c] = 0;
        prev_mdir[c] = 0; dir_run[c] = 0; ticks[c] = 0; speed[c] = 0;
        encoder[c] = '0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3: hall_map[idx] = data;
        REG_MAX_STEP:  max_step = int'(data[15:0]);
        REG_RAMP_INT:  ramp_int = int'(data[7:0]);
        REG_CUR_LIMIT: cur_lim  = int'($signed(data[15:0]));
        REG_CUR_GAIN:  gain     = int'(data[15:0]);
        default: ;
      endcase
    endfunction

    function void count_step(int c, bit fwd);
      bit same;
      same = fwd ? prev_mdir[c] : !prev_mdir[c];
      encoder[c] = fwd ? encoder[c] + 1 : encoder[c] - 1;
      if (same) begin
        if (dir_run[c] < RUN_CAP) dir_run[c]++;
      end else begin
        dir_run[c] = 0;
      end
      if (dir_run[c] >= DIR_STEPS) speed[c] = fwd ? ticks[c] : -ticks[c];
      ticks[c] = 0;
      prev_mdir[c] = fwd;
    endfunction

    function void note_tick(tick_t t);
      drive_t  r;
      int      c, stp, p, target, diff, mag, m;
      longint  over, lower;
      bit      fwd, back;
      c = t.chan;
      r = '{default: '0};
      r.chan = t.chan;
      if (t.hall >= 1 && t.hall <= 6) last_hall[c] = t.hall;
      stp = int'((hall_map[c] >> (3 * last_hall[c])) & 24'h7);
      if (t.en) begin
        if (ramp_cnt[c] < ramp_int) begin
          ramp_cnt[c]++;
        end else begin
          target = t.dir ? int'(t.duty) : -int'(t.duty);
          diff = target - prev_sduty[c];
          mag = diff < 0 ? -diff : diff;
          if (mag <= max_step) begin
            app_duty[c] = t.duty; app_dir[c] = t.dir; prev_sduty[c] = target;
          end else begin
            m = diff > 0 ? prev_sduty[c] + max_step : prev_sduty[c] - max_step;
            if (m >= 0) begin
              app_duty[c] = m & 16'hffff; app_dir[c] = 1;
            end else begin
              app_duty[c] = (-m) & 16'hffff; app_dir[c] = 0;
            end
            prev_sduty[c] = m;
          end
          ramp_cnt[c] = 0;
        end
        if (int'(t.cur) > cur_lim) begin
          over = longint'(t.cur) - longint'(cur_lim);
          lower = (over * gain) >>> 8;
          if (lower >= app_duty[c]) app_duty[c] = 0;
          else app_duty[c] = app_duty[c] - int'(lower);
        end
        r.active = 1;
        r.dir = app_dir[c];
        r.duty = app_duty[c][15:0];
      end
      p = prev_step[c];
      fwd  = (stp > p || (stp == 0 && p == 5)) && !(stp == 5 && p == 0);
      back = !fwd && (stp < p || (stp == 5 && p == 0));
      if (fwd) count_step(c, 1);
      else if (back) count_step(c, 0);
      if (ticks[c] > STALL_LIMIT) speed[c] = 0;
      else ticks[c]++;
      prev_step[c] = stp;
      if (ticks[c] < 65535) ticks[c]++;
      r.step = stp[2:0];
      r.count = encoder[c];
      r.speed = speed[c][16:0];
      awaited.push_back(r);
    endfunction

    function void check_result(drive_t got);
      drive_t e;
      if (awaited.size() == 0) begin
        $error("result on channel %0d with nothing awaited", got.chan);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.chan !== e.chan) begin
        $error("out_channel exp %0d got %0d", e.chan, got.chan); errors++;
      end
      if (got.active !== e.active) begin
        $error("drive_active exp %0d got %0d", e.active, got.active); errors++;
      end
      if (got.step !== e.step) begin
        $error("comm_step exp %0d got %0d", e.step, got.step); errors++;
      end
      if (got.dir !== e.dir) begin
        $error("drive_dir exp %0d got %0d", e.dir, got.dir); errors++;
      end
      if (got.duty !== e.duty) begin
        $error("drive_duty exp %0d got %0d", e.duty, got.duty); errors++;
      end
      if (got.count !== e.count) begin
        $error("step_count exp %0d got %0d", e.count, got.count); errors++;
      end
      if (got.speed !== e.speed) begin
        $error("ticks_per_step exp %0d got %0d", e.speed, got.speed); errors++;
      end
    endfunction
  endclass

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic [1:0]         channel;
  logic [2:0]         raw_hall;
  logic signed [15:0] current;
  logic               enable, dir_cmd;
  logic [15:0]        duty_cmd;
  logic               out_valid, out_stall;
  logic [1:0]         out_channel;
  logic               drive_active, drive_dir;
  logic [2:0]         comm_step;
  logic [15:0]        drive_duty;
  logic [31:0]        step_count;
  logic signed [16:0] ticks_per_step;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;

  bldc_hall_commutation_controller_top u_top (.*);

  drive_scoreboard sb;
  int idle_pct, stall_pct, hold_cnt, cycles;
  // rotor model per channel for well-formed Hall sequences
  int rotor_pos [4];
  bit rotor_fwd [4];
  logic [2:0] hall_seq [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor - sample on the rising edge
  always @(posedge clk) begin
    drive_t got;
    if (!rst && out_valid && !out_stall) begin
      got.chan = out_channel; got.active = drive_active; got.step = comm_step;
      got.dir = drive_dir; got.duty = drive_duty; got.count = step_count;
      got.speed = ticks_per_step;
      sb.check_result(got);
    end
  end

  // one input beat; called and returns on a falling edge
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    channel <= t.chan; raw_hall <= t.hall; current <= t.cur;
    enable <= t.en; duty_cmd <= t.duty; dir_cmd <= t.dir;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // let the pipe empty before touching config
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // map that turns the rotor sequence into steps 0..5; codes 0/7 random
  function automatic logic [23:0] ordered_map();
    logic [23:0] m;
    m = 24'($urandom());
    for (int i = 0; i < 6; i++) m[3*hall_seq[i] +: 3] = i[2:0];
    return m;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(200));
      default: return 16'($urandom());
    endcase
  endfunction

  // well-formed rotation with random content, plus some noise
  function automatic tick_t random_tick(int only_chan);
    tick_t t;
    int c;
    c = (only_chan >= 0) ? only_chan : $urandom_range(3);
    t.chan = 2'(c);
    if ($urandom_range(99) < 8) begin
      t.hall = 3'($urandom());
    end else begin
      if ($urandom_range(99) < 4) rotor_fwd[c] = !rotor_fwd[c];
      if ($urandom_range(99) < 60)
        rotor_pos[c] = rotor_fwd[c] ? (rotor_pos[c] + 1) % 6 : (rotor_pos[c] + 5) % 6;
      t.hall = hall_seq[rotor_pos[c]];
    end
    case ($urandom_range(9))
      0: t.cur = 16'sh7fff;
      1: t.cur = 16'sh8000;
      2, 3: t.cur = 16'(sb.cur_lim + int'($urandom_range(300)));
      default: t.cur = 16'($urandom());
    endcase
    t.en   = ($urandom_range(99) < 85);
    t.duty = pick16();
    t.dir  = ($urandom_range(99) < 80) ? rotor_fwd[c] : 1'($urandom_range(1));
    return t;
  endfunction

  task automatic random_config(bit ordered);
    for (int c = 0; c < 4; c++)
      write_reg(REG_MAP0 + 3'(c), ordered ? ordered_map() : 24'($urandom()));
    case ($urandom_range(3))
      0: write_reg(REG_MAX_STEP, 24'h0);
      1: write_reg(REG_MAX_STEP, 24'hffffff);
      default: write_reg(REG_MAX_STEP, 24'($urandom_range(2000)));
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_RAMP_INT, 24'h0);
      1: write_reg(REG_RAMP_INT, 24'hff);
      default: write_reg(REG_RAMP_INT, 24'($urandom_range(6)));
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_CUR_LIMIT, 24'h008000);
      1: write_reg(REG_CUR_LIMIT, 24'h007fff);
      default: write_reg(REG_CUR_LIMIT, 24'($urandom()));
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_CUR_GAIN, 24'h0);
      1: write_reg(REG_CUR_GAIN, 24'hffff);
      default: write_reg(REG_CUR_GAIN, 24'($urandom_range(1024)));
    endcase
  endtask

  initial begin
    tick_t t;
    int idle_set [4] = '{0, 80, 0, 13};
    int stall_set [4] = '{0, 0, 80, 13};
    sb = new();
    rst = 1; in_valid = 0; channel = 0; raw_hall = 0; current = 0; enable = 0;
    duty_cmd = 0; dir_cmd = 0; cfg_valid = 0; cfg_index = REG_MAP0; cfg_data = 0;
    out_stall = 0; idle_pct = 0; stall_pct = 0; hold_cnt = 0; cycles = 0;
    for (int c = 0; c < 4; c++) begin
      rotor_pos[c] = 0; rotor_fwd[c] = 1;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset config, every Hall code incl. invalid 0 and 7,
    // current and duty extremes, enable off/on, both directions
    for (int h = 0; h < 8; h++) begin
      t = '{chan: 2'(h % 4), hall: 3'(h), cur: (h % 2) ? 16'sh7fff : 16'sh8000,
            en: h != 3, duty: (h % 3 == 0) ? 16'hffff : 16'h0, dir: h[0]};
      send_tick(t);
    end
    drain();
    // ordered maps, instant ramp, large step, overshoot that clamps duty at zero
    for (int c = 0; c < 4; c++) write_reg(REG_MAP0 + 3'(c), ordered_map());
    write_reg(REG_RAMP_INT, 24'h0);
    write_reg(REG_MAX_STEP, 24'd40000);
    write_reg(REG_CUR_LIMIT, 24'd100);
    write_reg(REG_CUR_GAIN, 24'hffff);
    for (int i = 0; i < 14; i++) begin
      // forward run of steps, then one reversal, 5->0 wrap and 0->5 back
      rotor_pos[0] = (i < 10) ? (i % 6) : ((i == 10) ? 5 : (i == 11 ? 0 : 5));
      t = '{chan: 2'd0, hall: hall_seq[rotor_pos[0]], cur: (i == 13) ? 16'sh7fff : 16'sd50,
            en: 1'b1, duty: (i % 2) ? 16'hffff : 16'd1000, dir: i < 12};
      send_tick(t);
    end
    drain();

    // random phases over the idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      random_config(ph != 1);
      for (int i = 0; i < 420; i++) send_tick(random_tick(-1));
      drain();
    end

    // back-pressure: receiver holds off while the sender keeps offering
    idle_pct = 0; stall_pct = 0;
    @(posedge clk);
    hold_cnt = 300;
    @(negedge clk);
    for (int i = 0; i < 80; i++) send_tick(random_tick(-1));
    drain();

    // channel 1 alone: its ticks take the Hall code of its rotor model,
    // noise overridden, then the rotor steps on
    write_reg(REG_MAP1, ordered_map());
    for (int i = 0; i < 60; i++) begin
      t = random_tick(1);
      t.hall = hall_seq[rotor_pos[1]];
      send_tick(t);
    end
    rotor_pos[1] = (rotor_pos[1] + 1) % 6;
    for (int i = 0; i < 8; i++) send_tick(random_tick(1));
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
